>>> src/mts_pkg.sv
package mts_pkg;

  localparam int DEPTH  = 1024;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  // one stored entry: value and running minimum from the bottom up
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] min_value;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_t;

endpackage

>>> src/mts_ram.sv
module mts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/min_tracking_stack.sv
// Push, peek, refused operations and a pop that empties the stack give their word in the
// cycle after acceptance. A pop that leaves at least one entry refetches the new top from
// RAM in S_FILL and registers its word from the read data. Throughput: one word per cycle
// while rsp_ready holds, except such a pop, which holds off input during the RAM read.
// Reset (synchronous, rst high): stack empty, no word pending; RAM contents are left as is.
module min_tracking_stack
  import mts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // top entry is cached in registers; RAM holds entries 0 .. count-2
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  entry_t             top, top_next;
  logic               top_load;
  rsp_t               rsp_next;
  logic               rsp_load;

  logic               accept;
  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  entry_t             rd_data;
  logic signed [31:0] push_min;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign push_min  = (count != '0 && top.min_value < req.value) ? top.min_value : req.value;
  assign wr_addr   = ADDR_W'(count - CNT_W'(1));
  assign rd_addr   = ADDR_W'(count - CNT_W'(2));

  mts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    top_next   = top;
    top_load   = 1'b0;
    rsp_load   = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rsp_next   = '{top_value: top.value, min_value: top.min_value,
                   is_empty: 1'b0, status: ST_OK};
    if (count == '0) begin
      rsp_next.top_value = '0;
      rsp_next.min_value = '0;
      rsp_next.is_empty  = 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (req.op)
            OP_PUSH: begin
              rsp_load = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                rsp_next.status = ST_FULL;
              end else begin
                // old top drops into RAM below the new one
                wr_en      = (count != '0);
                top_next   = '{value: req.value, min_value: push_min};
                top_load   = 1'b1;
                count_next = count + CNT_W'(1);
                rsp_next   = '{top_value: req.value, min_value: push_min,
                               is_empty: 1'b0, status: ST_OK};
              end
            end
            OP_POP: begin
              if (count == '0) begin
                rsp_load        = 1'b1;
                rsp_next.status = ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
                if (count == CNT_W'(1)) begin
                  rsp_load = 1'b1;
                  rsp_next = '{top_value: '0, min_value: '0, is_empty: 1'b1, status: ST_OK};
                end else begin
                  rd_en      = 1'b1;
                  state_next = S_FILL;
                end
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        top_next   = rd_data;
        top_load   = 1'b1;
        rsp_load   = 1'b1;
        rsp_next   = '{top_value: rd_data.value, min_value: rd_data.min_value,
                       is_empty: 1'b0, status: ST_OK};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (top_load) begin
      top <= top_next;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_fill_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> $past(accept) && $past(req.op) == OP_POP)
    else $error("refetch without a pop");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_no_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !req_ready)
    else $error("input taken during refetch");

  a_top_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && count != '0) |-> top.min_value <= top.value)
    else $error("cached minimum above cached top");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |-> (rsp.top_value == '0 && rsp.min_value == '0))
    else $error("empty word with nonzero fields");

endmodule

>>> tb/min_tracking_stack_test.sv
module min_tracking_stack_test
  import mts_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // op code 3 has no name in the package; the block treats it as a peek
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int QUIET_LIMIT = 1000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_SHOWN   = 10;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct {
    req_t word;
    bit   wait_drain;
  } queued_op_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  queued_op_t pending_ops[$];
  rsp_t       expected_words[$];

  // shadow stack, kept in step with every accepted op
  entry_t      shadow[DEPTH];
  int unsigned shadow_fill = 0;

  int unsigned gen_depth   = 0;
  int unsigned words_sent  = 0;
  int unsigned words_back  = 0;
  int unsigned words_got   = 0;
  int unsigned mismatches  = 0;
  int unsigned quiet_count = 0;
  int          send_gap    = 0;
  int          hold_left   = 0;

  min_tracking_stack u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_t apply_stack_op(req_t w);
    rsp_t   r;
    entry_t e;
    r = '0;
    r.status = ST_OK;
    case (w.op)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.value     = w.value;
          e.min_value = w.value;
          if (shadow_fill > 0 && shadow[shadow_fill - 1].min_value < w.value)
            e.min_value = shadow[shadow_fill - 1].min_value;
          shadow[shadow_fill] = e;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_fill--;
      end
      default: ;
    endcase
    if (shadow_fill == 0) begin
      r.is_empty = 1'b1;
    end else begin
      r.top_value = shadow[shadow_fill - 1].value;
      r.min_value = shadow[shadow_fill - 1].min_value;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%t: %s", $realtime, what);
  endtask

  task automatic check_word(rsp_t got);
    rsp_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word %0d with nothing expected: top %0d min %0d empty %0b st %0d",
                                words_got, got.top_value, got.min_value, got.is_empty,
                                got.status));
    end else begin
      want = expected_words.pop_front();
      if (got.top_value != want.top_value || got.min_value != want.min_value ||
          got.is_empty != want.is_empty || got.status != want.status)
        report_mismatch($sformatf(
          "word %0d: want top %0d min %0d empty %0b st %0d, got top %0d min %0d empty %0b st %0d",
          words_got, want.top_value, want.min_value, want.is_empty, want.status,
          got.top_value, got.min_value, got.is_empty, got.status));
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom;
    if (sel < 8) return $signed($urandom_range(16)) - 8;
    case ($urandom_range(3))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return OP_PUSH;
    r = $urandom_range(9);
    if (r < 6) return OP_POP;
    if (r < 9) return OP_PEEK;
    return OP_SPARE;
  endfunction

  task automatic add_op(logic [1:0] op, logic signed [31:0] v, bit wait_drain = 1'b0);
    queued_op_t q;
    q.word.op    = op;
    q.word.value = v;
    q.wait_drain = wait_drain;
    pending_ops.push_back(q);
    if (op == OP_PUSH && gen_depth < DEPTH) gen_depth++;
    if (op == OP_POP && gen_depth > 0) gen_depth--;
  endtask

  // sender: one word per handshake; after each acceptance a gap is drawn, random or zero by phase
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (rsp_valid && rsp_ready) words_back++;
      if (req_valid && req_ready) begin
        expected_words.push_back(apply_stack_op(req));
        words_sent++;
        send_gap = ((words_sent / 128) % 4 == 0) ? 0 : $urandom_range(4);
      end
      if (!req_valid || req_ready) begin
        if (send_gap == 0 && pending_ops.size() > 0 &&
            !(pending_ops[0].wait_drain && words_back != words_sent)) begin
          req_valid <= 1'b1;
          req       <= pending_ops[0].word;
          pending_ops.pop_front();
        end else begin
          req_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // receiver: random stalls, a couple of long hold-offs to back the block up
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        check_word(rsp);
        words_got++;
        if (words_got == 40 || words_got == 1000) hold_left = LONG_HOLD;
        else hold_left = ((words_got / 160) % 3 == 0) ? 0 : $urandom_range(4);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_ready <= (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count == QUIET_LIMIT) begin
        $display("min_tracking_stack_test failed");
        $finish;
      end
    end
  end

  initial begin
    // directed: empty-stack cases, extremes, ties, unused op code
    add_op(OP_POP, $urandom);
    add_op(OP_PEEK, $urandom);
    add_op(OP_SPARE, $urandom);
    add_op(OP_PUSH, 0);
    add_op(OP_PUSH, VAL_MAX);
    add_op(OP_PUSH, VAL_MIN);
    add_op(OP_PUSH, -1);
    add_op(OP_PUSH, VAL_MIN);
    add_op(OP_PEEK, $urandom);
    add_op(OP_SPARE, $urandom);
    repeat (5) add_op(OP_POP, $urandom);
    add_op(OP_POP, $urandom);
    add_op(OP_PUSH, -1);
    add_op(OP_PUSH, 5);
    add_op(OP_PUSH, -3);
    add_op(OP_PUSH, -3);
    repeat (4) add_op(OP_POP, $urandom);
    add_op(OP_POP, $urandom);

    // random walk at shallow depth
    add_op(pick_op(50), pick_value(), 1'b1);
    repeat (59) add_op(pick_op(50), pick_value());

    // fill to the top, then knock on it
    add_op(OP_PUSH, pick_value(), 1'b1);
    while (gen_depth < DEPTH)
      add_op(($urandom_range(19) == 0) ? OP_PEEK : OP_PUSH, pick_value());
    repeat (8) add_op(OP_PUSH, pick_value());
    repeat (40) add_op(pick_op(60), pick_value());

    // back off from the top
    add_op(OP_POP, pick_value(), 1'b1);
    repeat (29) add_op(OP_POP, pick_value());

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || req_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("min_tracking_stack_test passed");
    end else begin
      $display("min_tracking_stack_test failed");
    end
    $finish;
  end

endmodule
